// ===== sv/bee_pkg.sv =====
// ----------------------------------------------------------------------------
// bee_pkg
// Shared constants and types for the byte entropy estimator.
// ----------------------------------------------------------------------------
package bee_pkg;
	localparam int NUM_BINS = 256;
	localparam int MANT_BITS = 30;

	typedef struct packed {
		logic [7:0] byte_value;
		logic last_byte;
	} bee_req_t;
endpackage

// ===== sv/bee_front.sv =====
// ----------------------------------------------------------------------------
// bee_front
// Input front end: a two-entry queue that decouples input requests from the
// histogram engine.
// ----------------------------------------------------------------------------
module bee_front (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  bee_pkg::bee_req_t in_req,
	output logic out_valid,
	input  logic out_ready,
	output bee_pkg::bee_req_t out_req
);
	import bee_pkg::*;

	bee_req_t mem_q [2];
	logic wr_q, rd_q;
	logic [1:0] cnt_q;
	logic push, pop;

	assign in_ready = (cnt_q != 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign out_req = mem_q[rd_q];
	assign push = in_valid && in_ready;
	assign pop = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= in_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			if (push && !pop) cnt_q <= cnt_q + 2'd1;
			else if (pop && !push) cnt_q <= cnt_q - 2'd1;
		end
	end

`ifndef SYNTHESIS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n) cnt_q != 2'd3)
		else $error("queue count out of range");
	a_full_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2 && !pop) |=> cnt_q == 2'd2)
		else $error("full queue lost an entry");
	a_empty_no_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd0) |-> !pop)
		else $error("pop from empty queue");
`endif
endmodule

// ===== sv/bee_log2.sv =====
// ----------------------------------------------------------------------------
// bee_log2
// Iterative fixed-point log2: one squaring step per cycle.
// ----------------------------------------------------------------------------
module bee_log2 #(
	parameter int XW = 21,
	parameter int FRAC_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [XW-1:0] x,
	output logic done,
	output logic [FRAC_BITS+5:0] result
);
	import bee_pkg::*;

	localparam int KW = $clog2(FRAC_BITS + 1);
	localparam int EW = 6;

	logic [31:0] m_q;
	logic [FRAC_BITS-1:0] frac_q;
	logic [EW-1:0] e_q;
	logic [KW-1:0] k_q;
	logic busy_q;
	logic [EW-1:0] e_c;
	logic [63:0] x_ext, mant_c, sq_c;
	logic [31:0] m_next;

	always_comb begin
		e_c = '0;
		for (int i = 0; i < XW; i++) begin
			if (x[i]) e_c = EW'(i);
		end
		x_ext = 64'(x);
		if (e_c <= EW'(MANT_BITS)) mant_c = x_ext << (EW'(MANT_BITS) - e_c);
		else mant_c = x_ext >> (e_c - EW'(MANT_BITS));
		sq_c = (64'(m_q) * 64'(m_q)) >> MANT_BITS;
		m_next = sq_c[31:0];
	end

	assign result = {e_q, frac_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			k_q <= '0;
			m_q <= '0;
			frac_q <= '0;
			e_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				k_q <= '0;
				m_q <= mant_c[31:0];
				e_q <= e_c;
				frac_q <= '0;
			end else if (busy_q) begin
				if (m_next[31]) begin
					m_q <= m_next >> 1;
					frac_q <= {frac_q[FRAC_BITS-2:0], 1'b1};
				end else begin
					m_q <= m_next;
					frac_q <= {frac_q[FRAC_BITS-2:0], 1'b0};
				end
				if (k_q == KW'(FRAC_BITS - 1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
				k_q <= k_q + 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy_q))
		else $error("log2 done without work");
	a_k_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> k_q < KW'(FRAC_BITS))
		else $error("log2 step count overrun");
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy_q)
		else $error("log2 busy after done");
`endif
endmodule

// ===== sv/bee_back.sv =====
// ----------------------------------------------------------------------------
// bee_back
// Histogram engine: counts bytes into a memory, then on a last byte sweeps
// all bins, sums c*log2(c), divides and clears the bins behind the sweep.
// ----------------------------------------------------------------------------
module bee_back #(
	parameter int COUNT_BITS = 20,
	parameter int FRAC_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  bee_pkg::bee_req_t in_req,
	output logic res_valid,
	input  logic res_ready,
	output logic [FRAC_BITS+3:0] res_entropy,
	output logic [COUNT_BITS:0] res_total,
	output logic res_ovf
);
	import bee_pkg::*;

	localparam int CW = COUNT_BITS + 1;
	localparam int LW = FRAC_BITS + 6;
	localparam int SW = CW + LW;
	localparam int HW = FRAC_BITS + 4;
	localparam logic [CW-1:0] LIMIT = CW'(1) << COUNT_BITS;
	localparam int DK = SW;
	localparam int DCW = $clog2(DK + 1);

	typedef enum logic [3:0] {
		S_INIT, S_IDLE, S_CNT, S_WAIT, S_RD, S_LOG, S_MUL, S_NLOG, S_NMUL, S_DIV, S_OUT
	} state_t;

	state_t state_q;
	logic [CW-1:0] mem [NUM_BINS];
	logic [CW-1:0] rd_s1;
	logic [7:0] addr_q;
	logic [CW-1:0] n_q;
	logic ovf_q;
	logic [SW-1:0] sum_q, prod_q, rem_q, quo_q;
	logic [DCW-1:0] dk_q;
	logic lg_start;
	logic lg_done;
	logic [LW-1:0] lg_res;
	logic [CW-1:0] lg_x;
	logic [SW:0] trial;
	logic accept;

	// A request is taken in the cycle after its bin read was issued.
	assign in_ready = (state_q == S_CNT);
	assign accept = in_valid && in_ready;
	assign trial = {rem_q, quo_q[SW-1]} - {1'b0, {(SW-CW){1'b0}}, n_q};

	bee_log2 #(.XW(CW), .FRAC_BITS(FRAC_BITS)) u_log2 (
		.clk(clk), .arst_n(arst_n), .start(lg_start), .x(lg_x),
		.done(lg_done), .result(lg_res)
	);

	// Memory port: one read and one write per cycle.
	logic mem_we;
	logic [7:0] mem_wa, mem_ra;
	logic [CW-1:0] mem_wd;
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		rd_s1 <= mem[mem_ra];
	end

	always_comb begin
		mem_we = 1'b0;
		mem_wa = addr_q;
		mem_wd = '0;
		mem_ra = in_req.byte_value;
		lg_start = 1'b0;
		lg_x = rd_s1;
		unique case (state_q)
			S_INIT: begin
				mem_we = 1'b1;
			end
			S_CNT: begin
				mem_we = accept && (n_q != LIMIT);
				mem_wa = in_req.byte_value;
				mem_wd = rd_s1 + CW'(1);
			end
			S_RD: begin
				mem_ra = addr_q;
			end
			S_LOG: begin
				lg_start = (rd_s1 != '0);
				mem_we = 1'b1;
			end
			S_NLOG: begin
				lg_start = 1'b1;
				lg_x = n_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			addr_q <= '0;
			n_q <= '0;
			ovf_q <= 1'b0;
			sum_q <= '0;
			prod_q <= '0;
			rem_q <= '0;
			quo_q <= '0;
			dk_q <= '0;
			res_valid <= 1'b0;
			res_entropy <= '0;
			res_total <= '0;
			res_ovf <= 1'b0;
		end else begin
			if (res_valid && res_ready) res_valid <= 1'b0;
			unique case (state_q)
				S_INIT: begin
					addr_q <= addr_q + 8'd1;
					if (addr_q == 8'hFF) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_valid) state_q <= S_CNT;
				end
				S_CNT: begin
					if (accept) begin
						if (n_q != LIMIT) begin
							n_q <= n_q + 1'b1;
						end else begin
							ovf_q <= 1'b1;
						end
						state_q <= in_req.last_byte ? S_WAIT : S_IDLE;
					end
				end
				S_WAIT: begin
					addr_q <= '0;
					sum_q <= '0;
					state_q <= S_RD;
				end
				S_RD: state_q <= S_LOG;
				S_LOG: begin
					if (rd_s1 == '0) begin
						addr_q <= addr_q + 8'd1;
						state_q <= (addr_q == 8'hFF) ? S_NLOG : S_RD;
					end else begin
						prod_q <= SW'(rd_s1);
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					if (lg_done) begin
						sum_q <= sum_q + SW'(prod_q[CW-1:0] * lg_res);
						addr_q <= addr_q + 8'd1;
						state_q <= (addr_q == 8'hFF) ? S_NLOG : S_RD;
					end
				end
				S_NLOG: begin
					state_q <= S_NMUL;
				end
				S_NMUL: begin
					if (lg_done) begin
						prod_q <= SW'(n_q * lg_res);
						state_q <= S_DIV;
						dk_q <= '0;
						rem_q <= '0;
					end
				end
				S_DIV: begin
					if (dk_q == '0) begin
						quo_q <= (sum_q >= prod_q) ? '0 : prod_q - sum_q;
						dk_q <= dk_q + 1'b1;
					end else begin
						if (!trial[SW]) begin
							rem_q <= trial[SW-1:0];
							quo_q <= {quo_q[SW-2:0], 1'b1};
						end else begin
							rem_q <= {rem_q[SW-2:0], quo_q[SW-1]};
							quo_q <= {quo_q[SW-2:0], 1'b0};
						end
						dk_q <= dk_q + 1'b1;
						if (dk_q == DCW'(DK)) state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (!res_valid) begin
						res_valid <= 1'b1;
						res_entropy <= (quo_q > SW'(8 << FRAC_BITS)) ?
							HW'(8 << FRAC_BITS) : quo_q[HW-1:0];
						res_total <= n_q;
						res_ovf <= ovf_q;
						n_q <= '0;
						ovf_q <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_n_limit: assert property (@(posedge clk) disable iff (!arst_n) n_q <= LIMIT)
		else $error("byte count beyond limit");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_CNT) |-> !accept)
		else $error("request taken during sweep");
	a_res_after_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(state_q) == S_OUT)
		else $error("result raised outside output step");
`endif
endmodule

// ===== sv/byte_entropy_estimator_top.sv =====
// A request is registered in the two-entry queue, then counted by the engine: the
// counter reads the byte's bin, then writes the update, and takes no new byte in between.
// On a last byte the sweep sets up, reads each bin, runs log2 and a multiply-add on
// each used bin, then takes log2(N), divides and registers the result. Reset clears
// control at once, then a clearing pass over all 256 bins runs before the first byte
// is taken.
// ----------------------------------------------------------------------------
// byte_entropy_estimator_top
// Shannon byte entropy of a section, bits per byte, in fixed point.
// ----------------------------------------------------------------------------
module byte_entropy_estimator_top #(
	parameter int COUNT_BITS = 20,
	parameter int FRAC_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [7:0] s_tdata, // byte_value
	input  logic s_tlast, // last_byte
	output logic m_tvalid,
	input  logic m_tready,
	output logic [47:0] m_tdata // entropy_bits[19:0], byte_total[40:20], count_overflow[41]
);
	import bee_pkg::*;

	bee_req_t in_req, q_req;
	logic q_valid, q_ready;
	logic [FRAC_BITS+3:0] ent;
	logic [COUNT_BITS:0] tot;
	logic ovf;

	assign in_req.byte_value = s_tdata;
	assign in_req.last_byte = s_tlast;

	bee_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(s_tvalid), .in_ready(s_tready),
		.in_req(in_req), .out_valid(q_valid), .out_ready(q_ready), .out_req(q_req)
	);

	bee_back #(.COUNT_BITS(COUNT_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .in_valid(q_valid), .in_ready(q_ready),
		.in_req(q_req), .res_valid(m_tvalid), .res_ready(m_tready),
		.res_entropy(ent), .res_total(tot), .res_ovf(ovf)
	);

	assign m_tdata = {6'd0, ovf, 21'(tot), 20'(ent)};
endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the byte entropy estimator. Sections of bytes are
// streamed into the slave side with random gaps. Each accepted request feeds a
// bench-side histogram and log2 predictor. Every result on the master side is
// compared field by field with the oldest predicted entropy record.
// ----------------------------------------------------------------------------
module tb_top;
	import bee_pkg::*;

	localparam int COUNT_BITS = 20;
	localparam int FRAC_BITS = 16;
	localparam longint unsigned COUNT_LIMIT = 64'd1 << COUNT_BITS;
	localparam int IDLE_LIMIT = 60000;

	typedef struct {
		logic [7:0] byte_value;
		logic last_byte;
		bit drain;
		bit no_gap;
		int rep;
	} byte_run_t;

	typedef struct {
		logic [19:0] entropy_bits;
		logic [20:0] byte_total;
		logic count_overflow;
	} entropy_rec_t;

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [7:0] s_tdata = 0;
	logic s_tlast = 0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [47:0] m_tdata;

	byte_run_t pending_runs[$];
	entropy_rec_t expected_recs[$];
	longint unsigned hist[NUM_BINS];
	longint unsigned section_bytes;
	bit section_ovf;
	int mismatches = 0;
	int idle_cycles = 0;
	bit quiet = 0;

	byte_entropy_estimator_top #(.COUNT_BITS(COUNT_BITS), .FRAC_BITS(FRAC_BITS)) dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always #1 clk = ~clk;

	// Squaring log2: integer part from the top set bit, fraction bit by bit.
	function automatic longint unsigned log2_fixed(longint unsigned x);
		int e;
		longint unsigned m;
		longint unsigned frac;
		e = 0;
		frac = 0;
		if (x == 0) return 0;
		while (e < 63 && (x >> (e + 1)) != 0) e++;
		if (e <= MANT_BITS) m = x << (MANT_BITS - e);
		else m = x >> (e - MANT_BITS);
		for (int k = 0; k < FRAC_BITS; k++) begin
			m = (m * m) >> MANT_BITS;
			frac = frac << 1;
			if (m >= (64'd2 << MANT_BITS)) begin
				m = m >> 1;
				frac = frac | 1;
			end
		end
		return (longint'(e) << FRAC_BITS) | frac;
	endfunction

	task automatic count_byte(input logic [7:0] b, input logic last);
		longint unsigned sum_clogc;
		longint unsigned total;
		longint unsigned h;
		entropy_rec_t rec;
		if (section_bytes < COUNT_LIMIT) begin
			hist[b]++;
			section_bytes++;
		end else begin
			section_ovf = 1;
		end
		if (last) begin
			sum_clogc = 0;
			for (int i = 0; i < NUM_BINS; i++)
				if (hist[i] != 0) sum_clogc += hist[i] * log2_fixed(hist[i]);
			total = section_bytes * log2_fixed(section_bytes);
			if (section_bytes == 0 || sum_clogc >= total) h = 0;
			else h = (total - sum_clogc) / section_bytes;
			if (h > (64'd8 << FRAC_BITS)) h = 64'd8 << FRAC_BITS;
			rec.entropy_bits = h[19:0];
			rec.byte_total = section_bytes[20:0];
			rec.count_overflow = section_ovf;
			expected_recs.insert(expected_recs.size(), rec);
			foreach (hist[i]) hist[i] = 0;
			section_bytes = 0;
			section_ovf = 0;
		end
	endtask

	task automatic report(input string what, input longint unsigned got,
			input longint unsigned want);
		$display("error: %s got %0d expected %0d at %0t", what, got, want, $realtime);
		mismatches++;
	endtask

	// Driver: one nonblocking write per signal per edge.
	byte_run_t cur;
	int left = 0;
	int gap = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 0;
			s_tlast <= 0;
			s_tdata <= 0;
		end else if (!s_tvalid || s_tready) begin
			if (left == 0 && pending_runs.size() > 0 && !(pending_runs[0].drain &&
					(s_tvalid || expected_recs.size() > 0))) begin
				cur = pending_runs.pop_front();
				left = cur.rep;
			end
			quiet = pending_runs.size() < 40;
			if (gap > 0) begin
				gap--;
				s_tvalid <= 0;
			end else if (left > 0) begin
				s_tdata <= cur.byte_value;
				s_tlast <= cur.last_byte && left == 1;
				s_tvalid <= 1;
				left--;
				if (!cur.no_gap && !quiet && $urandom_range(0, 7) == 0)
					gap = $urandom_range(1, 17);
			end else begin
				s_tvalid <= 0;
			end
		end
	end

	int stall = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 0;
		end else if (stall > 0) begin
			stall--;
			m_tready <= 0;
		end else if (!quiet && $urandom_range(0, 5) == 0) begin
			stall = $urandom_range(1, 17) - 1;
			m_tready <= 0;
		end else begin
			m_tready <= 1;
		end
	end

	// Monitor: predict on accepted requests, check accepted results.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) count_byte(s_tdata, s_tlast);
			if (m_tvalid && m_tready) begin
				if (expected_recs.size() == 0) begin
					report("unexpected result", m_tdata, 0);
				end else begin
					if (m_tdata[19:0] != expected_recs[0].entropy_bits)
						report("entropy_bits", m_tdata[19:0], expected_recs[0].entropy_bits);
					if (m_tdata[40:20] != expected_recs[0].byte_total)
						report("byte_total", m_tdata[40:20], expected_recs[0].byte_total);
					if (m_tdata[41] != expected_recs[0].count_overflow)
						report("count_overflow", m_tdata[41], expected_recs[0].count_overflow);
					void'(expected_recs.pop_front());
				end
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("byte_entropy_estimator_top: mismatch");
				$finish;
			end
		end
	end

	task automatic add_byte(input logic [7:0] b, input logic last, input int rep = 1,
			input bit no_gap = 0, input bit drain = 0);
		byte_run_t r;
		r.byte_value = b;
		r.last_byte = last;
		r.rep = rep;
		r.no_gap = no_gap;
		r.drain = drain;
		pending_runs.insert(pending_runs.size(), r);
	endtask

	initial begin
		int items;
		int len;
		int mode;
		int rep;
		logic [7:0] mask;
		logic [7:0] b;
		foreach (hist[i]) hist[i] = 0;
		section_bytes = 0;
		section_ovf = 0;

		// Single-byte sections at both extremes, then two equal halves.
		add_byte(8'h00, 1);
		add_byte(8'hff, 1);
		add_byte(8'h00, 0);
		add_byte(8'hff, 1);
		add_byte(8'haa, 0, 4);
		add_byte(8'haa, 1);
		add_byte(8'h55, 0);
		add_byte(8'h01, 0);
		add_byte(8'h80, 0);
		add_byte(8'h7f, 1);
		// The sender waits here until every result has come back.
		add_byte(8'h12, 1, 1, 0, 1);

		items = 0;
		while (items < 750) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 200) : $urandom_range(1, 12);
			mode = $urandom_range(0, 2);
			mask = (mode == 0) ? 8'hff : (mode == 1) ? 8'h03 : 8'($urandom);
			for (int i = 0; i < len; i++) begin
				b = 8'($urandom) & mask;
				rep = ($urandom_range(0, 9) == 0) ? $urandom_range(2, 6) : 1;
				add_byte(b, i == len - 1, rep, 0, i == 0 && $urandom_range(0, 19) == 0);
				items += rep;
			end
		end

		repeat (5) @(posedge clk);
		arst_n <= 1;
		while (pending_runs.size() > 0 || left > 0 || s_tvalid) @(posedge clk);
		while (expected_recs.size() > 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (mismatches == 0 && expected_recs.size() == 0)
			$display("byte_entropy_estimator_top: match");
		else
			$display("byte_entropy_estimator_top: mismatch");
		$finish;
	end
endmodule
